// File: hw/rtl/wst_pkg.sv
// Shared types and constants for the station tracking table.
package wst_pkg;

   // Default table depth
   localparam int TABLE_ENTRIES_DEFAULT = 64;

   // Field widths fixed by the frame header format
   localparam int ADDR_W    = 48;
   localparam int PACKETS_W = 32;
   localparam int SEEN_W    = 32;
   localparam int RSSI_W    = 8;

   // Frame acceptance constants
   localparam logic [11:0] MIN_FRAME_LENGTH = 12'd24;
   localparam logic [1:0]  KIND_MGMT        = 2'd0;
   localparam logic [1:0]  KIND_DATA        = 2'd1;
   localparam logic [1:0]  FTYPE_MGMT       = 2'd0;
   localparam logic [1:0]  FTYPE_DATA       = 2'd2;
   localparam logic [7:0]  SUBTYPE_MASK     = 8'hF0;
   localparam logic [7:0]  SUBTYPE_PROBE    = 8'h40;
   localparam int          GROUP_BIT        = 40;

   // Result codes
   typedef enum logic [1:0] {
      OUTCOME_IGNORED  = 2'd0,
      OUTCOME_UPDATED  = 2'd1,
      OUTCOME_INSERTED = 2'd2,
      OUTCOME_DROPPED  = 2'd3
   } outcome_type;

   // Decoded frame header
   typedef struct packed {
      logic              ignore;
      logic [ADDR_W-1:0] station;
      logic [ADDR_W-1:0] network;
      logic              associated;
   } decode_type;

   // Per-row fields: BSSID, association and packet count are read back on a hit,
   // RSSI and last-seen time ride along on every row write
   typedef struct packed {
      logic [ADDR_W-1:0]    network;
      logic                 associated;
      logic [PACKETS_W-1:0] packets;
      logic [RSSI_W-1:0]    strength;
      logic [SEEN_W-1:0]    last_seen;
   } row_status_type;

endpackage

// File: hw/rtl/wlan_station_tracking_table_top.sv
// Top level of the station tracking table: sequencer, row compare and row memories.
//
// Usage: drive one received frame header on the req_ ports and raise start
// while busy is low; the request is taken at that clock edge. Each request
// gives exactly one result on the rsp_ ports, marked by rsp_valid for one
// cycle; the receiver cannot stall and must take it then.
// An ignored frame (wrong kind, short, unsupported type or group station)
// gives its result in the cycle after the request; busy does not rise.
// Any other frame raises busy and walks the table one row per cycle through
// the single station-address compare, fed by the registered read port of
// the address memory. A miss (insert or drop) gives its result once every
// valid row has been compared; a hit ends the walk and gives its result
// after a read-modify-write of that row in the row status memory.
// busy falls in the cycle the result is shown, so a new request can be
// taken in that cycle.
// Reset (synchronous, active high) empties the table at once by clearing
// the row count; no clearing pass runs and row memories are not touched.
module wlan_station_tracking_table_top #(
   parameter int TABLE_ENTRIES = wst_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_packet_kind,
   input  logic [11:0]       req_frame_length,
   input  logic [7:0]        req_frame_control_low,
   input  logic [7:0]        req_frame_control_high,
   input  logic [47:0]       req_address_one,
   input  logic [47:0]       req_address_two,
   input  logic signed [7:0] req_signal_strength,
   input  logic [31:0]       req_timestamp,
   output logic              rsp_valid,
   output logic [1:0]        rsp_outcome,
   output logic [5:0]        rsp_slot_index,
   output logic [6:0]        rsp_station_count,
   output logic [31:0]       rsp_station_packets,
   output logic              rsp_station_associated
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int STATUS_W   = $bits(wst_pkg::row_status_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   wst_pkg::decode_type decode;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]               hit_idx_ff, hit_idx_in;
   logic [wst_pkg::ADDR_W-1:0]  sta_ff, sta_in;
   logic [wst_pkg::ADDR_W-1:0]  bss_ff, bss_in;
   logic                        assoc_ff, assoc_in;
   logic [wst_pkg::RSSI_W-1:0]  rssi_ff, rssi_in;
   logic [wst_pkg::SEEN_W-1:0]  seen_ff, seen_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   wst_pkg::outcome_type        rsp_outcome_ff, rsp_outcome_in;
   logic [5:0]                  rsp_slot_ff, rsp_slot_in;
   logic [6:0]                  rsp_count_ff, rsp_count_in;
   logic [31:0]                 rsp_packets_ff, rsp_packets_in;
   logic                        rsp_assoc_ff, rsp_assoc_in;

   logic                        addr_rd_en;
   logic [IW-1:0]               addr_rd_addr;
   logic [wst_pkg::ADDR_W-1:0]  addr_rd_data;
   logic                        row_wr_en;
   logic [IW-1:0]               row_wr_addr;
   logic                        addr_wr_en;
   logic                        status_rd_en;
   logic [IW-1:0]               status_rd_addr;
   wst_pkg::row_status_type     status_rd_data;
   wst_pkg::row_status_type     status_wr_data;
   logic [wst_pkg::PACKETS_W-1:0] packets_next;
   logic                        hit;
   logic [IW+5:0]               slot_wide;
   logic [CW+6:0]               count_wide;

   // Decode the incoming header
   wst_frame_decode u_decode (
      .packet_kind        (req_packet_kind),
      .frame_length       (req_frame_length),
      .frame_control_low  (req_frame_control_low),
      .frame_control_high (req_frame_control_high),
      .address_one        (req_address_one),
      .address_two        (req_address_two),
      .decode             (decode)
   );

   // Station address memory, read one row per cycle during the search
   wst_ram #(
      .WIDTH (wst_pkg::ADDR_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IW)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (sta_ff),
      .rd_en   (addr_rd_en),
      .rd_addr (addr_rd_addr),
      .rd_data (addr_rd_data)
   );

   // Row status memory: BSSID, association, packet count, RSSI, last seen
   wst_ram #(
      .WIDTH (STATUS_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IW)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (status_wr_data),
      .rd_en   (status_rd_en),
      .rd_addr (status_rd_addr),
      .rd_data (status_rd_data)
   );

   // Shared station compare against the row read last cycle
   assign hit = cmp_valid_ff && (addr_rd_data == sta_ff);

   // Saturating packet count of the hit row
   assign packets_next = (&status_rd_data.packets) ? status_rd_data.packets :
                         status_rd_data.packets + 32'd1;

   // Sequence the ignored report, search, insert, drop and update
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      hit_idx_in     = hit_idx_ff;
      sta_in         = sta_ff;
      bss_in         = bss_ff;
      assoc_in       = assoc_ff;
      rssi_in        = rssi_ff;
      seen_in        = seen_ff;
      rsp_valid_in   = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_packets_in = rsp_packets_ff;
      rsp_assoc_in   = rsp_assoc_ff;
      addr_rd_en     = 1'b0;
      addr_rd_addr   = ptr_ff[IW-1:0];
      addr_wr_en     = 1'b0;
      row_wr_en      = 1'b0;
      row_wr_addr    = hit_idx_ff;
      status_rd_en   = 1'b0;
      status_rd_addr = cmp_idx_ff;
      status_wr_data = status_rd_data;
      // Every row write carries the request's RSSI and arrival time
      status_wr_data.strength  = rssi_ff;
      status_wr_data.last_seen = seen_ff;
      slot_wide      = {6'd0, hit_idx_ff};
      count_wide     = {7'd0, count_ff};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (decode.ignore) begin
                  // Report an ignored frame right away
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = wst_pkg::OUTCOME_IGNORED;
                  rsp_slot_in    = 6'd0;
                  rsp_count_in   = count_wide[6:0];
                  rsp_packets_in = 32'd0;
                  rsp_assoc_in   = 1'b0;
               end else begin
                  // Capture the request and start the walk at row zero
                  sta_in   = decode.station;
                  bss_in   = decode.network;
                  assoc_in = decode.associated;
                  rssi_in  = $unsigned(req_signal_strength);
                  seen_in  = req_timestamp;
                  ptr_in   = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               // Fetch the hit row's status for the update
               status_rd_en = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               state_in     = ST_UPDATE;
            end else if (ptr_ff < count_ff) begin
               // Issue the next row read
               addr_rd_en   = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = ptr_ff[IW-1:0];
               ptr_in       = ptr_ff + CW'(1);
            end else if (count_ff < CW'(TABLE_ENTRIES)) begin
               // Append a new row
               row_wr_en                 = 1'b1;
               addr_wr_en                = 1'b1;
               row_wr_addr               = count_ff[IW-1:0];
               status_wr_data.network    = bss_ff;
               status_wr_data.associated = assoc_ff;
               status_wr_data.packets    = 32'd1;
               count_in                  = count_ff + CW'(1);
               slot_wide                 = {6'd0, count_ff[IW-1:0]};
               count_wide                = {7'd0, count_in};
               rsp_valid_in              = 1'b1;
               rsp_outcome_in            = wst_pkg::OUTCOME_INSERTED;
               rsp_slot_in               = slot_wide[5:0];
               rsp_count_in              = count_wide[6:0];
               rsp_packets_in            = 32'd1;
               rsp_assoc_in              = assoc_ff;
               state_in                  = ST_IDLE;
            end else begin
               // Drop the frame, table full
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = wst_pkg::OUTCOME_DROPPED;
               rsp_slot_in    = 6'd0;
               rsp_count_in   = count_wide[6:0];
               rsp_packets_in = 32'd0;
               rsp_assoc_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            // Write back the hit row and report it
            row_wr_en              = 1'b1;
            status_wr_data.packets = packets_next;
            if (assoc_ff) begin
               status_wr_data.network    = bss_ff;
               status_wr_data.associated = 1'b1;
            end
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = wst_pkg::OUTCOME_UPDATED;
            rsp_slot_in    = slot_wide[5:0];
            rsp_count_in   = count_wide[6:0];
            rsp_packets_in = packets_next;
            rsp_assoc_in   = status_wr_data.associated;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, request fields and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff     <= cmp_idx_in;
      hit_idx_ff     <= hit_idx_in;
      sta_ff         <= sta_in;
      bss_ff         <= bss_in;
      assoc_ff       <= assoc_in;
      rssi_ff        <= rssi_in;
      seen_ff        <= seen_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_packets_ff <= rsp_packets_in;
      rsp_assoc_ff   <= rsp_assoc_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_outcome            = rsp_outcome_ff;
   assign rsp_slot_index         = rsp_slot_ff;
   assign rsp_station_count      = rsp_count_ff;
   assign rsp_station_packets    = rsp_packets_ff;
   assign rsp_station_associated = rsp_assoc_ff;

   // Row count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("row count exceeds table depth");

   // A pending compare exists only during the search
   a_cmp_in_search: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == ST_SEARCH))
      else $error("row compare pending outside search");

   // The update cycle is followed by an updated result
   a_update_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (rsp_valid && (rsp_outcome == wst_pkg::OUTCOME_UPDATED)))
      else $error("update cycle gave no updated result");

   // An accepted request either reports at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor reported");

endmodule

// File: hw/rtl/wst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/wst_frame_decode.sv
// Frame header filter: picks station, BSSID and association or flags the frame ignored.
module wst_frame_decode (
   input  logic [1:0]            packet_kind,
   input  logic [11:0]           frame_length,
   input  logic [7:0]            frame_control_low,
   input  logic [7:0]            frame_control_high,
   input  logic [47:0]           address_one,
   input  logic [47:0]           address_two,
   output wst_pkg::decode_type   decode
);

   logic [1:0] ftype;
   logic       to_ds;
   logic       from_ds;
   logic       kind_ok;
   logic       have;

   assign ftype   = frame_control_low[3:2];
   assign to_ds   = frame_control_high[0];
   assign from_ds = frame_control_high[1];
   assign kind_ok = (packet_kind == wst_pkg::KIND_MGMT) || (packet_kind == wst_pkg::KIND_DATA);

   // Select station and BSSID by frame type and DS bits
   always_comb begin
      have               = 1'b0;
      decode.station     = '0;
      decode.network     = '0;
      decode.associated  = 1'b0;
      if (ftype == wst_pkg::FTYPE_DATA) begin
         if (to_ds && !from_ds) begin
            decode.network    = address_one;
            decode.station    = address_two;
            decode.associated = 1'b1;
            have              = 1'b1;
         end else if (!to_ds && from_ds) begin
            decode.station    = address_one;
            decode.network    = address_two;
            decode.associated = 1'b1;
            have              = 1'b1;
         end
      end else if ((ftype == wst_pkg::FTYPE_MGMT) &&
                   ((frame_control_low & wst_pkg::SUBTYPE_MASK) == wst_pkg::SUBTYPE_PROBE)) begin
         decode.station = address_two;
         have           = 1'b1;
      end
      // Drop short frames, foreign kinds, unsupported types and group stations
      decode.ignore = !kind_ok || (frame_length < wst_pkg::MIN_FRAME_LENGTH) || !have ||
                      decode.station[wst_pkg::GROUP_BIT];
   end

endmodule
